### rtl/truss_element_stiffness_3d_assert.svh
// assertion macros for the truss element stiffness block
`ifndef TRUSS_ELEMENT_STIFFNESS_3D_ASSERT_SVH
`define TRUSS_ELEMENT_STIFFNESS_3D_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tes_pkg.sv
// shared types and constants of the truss element stiffness block
package tes_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SUM_W   = 2 * DIFF_W;
  localparam int LEN_W   = SUM_W / 2;
  localparam int REM_W   = LEN_W + 3;
  localparam int PROD_W  = 64;
  localparam int VAL_W   = 48;
  localparam int IDX_W   = 3;
  localparam int AXES    = 3;

  localparam logic [IDX_W-1:0] AXES_PER_NODE = 3'd3;
  localparam logic [IDX_W-1:0] LAST_IDX      = 3'd5;

  localparam logic [VAL_W-1:0] VAL_POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

  // one bar as it enters
  typedef struct packed {
    logic signed [COORD_W-1:0] node_a_x;
    logic signed [COORD_W-1:0] node_a_y;
    logic signed [COORD_W-1:0] node_a_z;
    logic signed [COORD_W-1:0] node_b_x;
    logic signed [COORD_W-1:0] node_b_y;
    logic signed [COORD_W-1:0] node_b_z;
    logic [COORD_W-1:0]        elastic_modulus;
    logic [COORD_W-1:0]        cross_area;
  } elem_t;

  // bar geometry after the length unit
  typedef struct packed {
    logic [LEN_W-1:0]                len;
    logic [AXES-1:0][DIFF_W-1:0]     mag;
    logic [AXES-1:0]                 neg;
    logic [COORD_W-1:0]              modulus;
    logic [COORD_W-1:0]              area;
  } root_res_t;

endpackage

### rtl/tes_if.sv
// bar and matrix entry channel interfaces
interface tes_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  node_a_x;
  logic signed [31:0]  node_a_y;
  logic signed [31:0]  node_a_z;
  logic signed [31:0]  node_b_x;
  logic signed [31:0]  node_b_y;
  logic signed [31:0]  node_b_z;
  logic [31:0]         elastic_modulus;
  logic [31:0]         cross_area;

  modport source (output valid, node_a_x, node_a_y, node_a_z, node_b_x, node_b_y,
                  node_b_z, elastic_modulus, cross_area, input ready);
  modport sink (input valid, node_a_x, node_a_y, node_a_z, node_b_x, node_b_y,
                node_b_z, elastic_modulus, cross_area, output ready);
endinterface

interface tes_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic signed [47:0] stiffness_value;
  logic               zero_length;
  logic               last_entry;

  modport source (output valid, row_index, col_index, stiffness_value, zero_length,
                  last_entry, input ready);
  modport sink (input valid, row_index, col_index, stiffness_value, zero_length,
                last_entry, output ready);
endinterface

### rtl/truss_element_stiffness_3d.sv
// top level: space truss element stiffness matrix generator
//
// in_word takes one bar per word: both node coordinates, modulus and area,
// all fixed point with FRAC_BITS fraction bits. out_word gives the 36 entries
// of the 6x6 global stiffness matrix in row-major order, one per word, with
// last_entry on row 5 column 5 and zero_length (value zero) for coincident nodes.
// Flow: a length unit (three squares, then a 33-step bit-pair square root),
// a divider unit (one multiply, then a restoring division, two quotient bits at a time, for EA/L
// with the three cosine lanes running alongside) and an emitter that walks
// the matrix through a four-register multiply pipeline.
// The three sections overlap, so a bar is taken while the previous one is still
// emitted; the square root unit takes no new bar until its last one is passed on.
// Reset (rst_n, synchronous) empties all three sections and drops out valid.
// When the receiver stalls, the whole emitter pipeline holds, the divider and
// length units finish and wait, and in_word.ready falls once they are full.
module truss_element_stiffness_3d #(
  parameter int FRAC_BITS = tes_pkg::FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  tes_in_if.sink    in_word,
  tes_out_if.source out_word
);

`include "truss_element_stiffness_3d_assert.svh"

  localparam int CW  = FRAC_BITS + 1;
  localparam int CCW = 2 * CW;
  localparam int PPW = 32 + CW;
  localparam int SW  = 32 + CCW;
  localparam int PW  = tes_pkg::PROD_W + CCW;
  localparam int FW  = PW - 2 * FRAC_BITS;
  localparam int VW  = tes_pkg::VAL_W;
  localparam int IW  = tes_pkg::IDX_W;
  localparam int KW  = tes_pkg::PROD_W;

  tes_pkg::elem_t     elem;
  tes_pkg::root_res_t root_res;
  logic               root_valid, root_ready;

  logic                             coef_valid, coef_ready;
  logic [KW-1:0]                    coef_k;
  logic [tes_pkg::AXES-1:0][CW-1:0] coef_cos;
  logic [tes_pkg::AXES-1:0]         coef_neg;
  logic                             coef_zero;

  assign elem.node_a_x        = in_word.node_a_x;
  assign elem.node_a_y        = in_word.node_a_y;
  assign elem.node_a_z        = in_word.node_a_z;
  assign elem.node_b_x        = in_word.node_b_x;
  assign elem.node_b_y        = in_word.node_b_y;
  assign elem.node_b_z        = in_word.node_b_z;
  assign elem.elastic_modulus = in_word.elastic_modulus;
  assign elem.cross_area      = in_word.cross_area;

  tes_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .in_elem   (elem),
    .res_valid (root_valid),
    .res_ready (root_ready),
    .res       (root_res)
  );

  tes_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_valid  (root_valid),
    .src_ready  (root_ready),
    .src        (root_res),
    .coef_valid (coef_valid),
    .coef_ready (coef_ready),
    .coef_k     (coef_k),
    .coef_cos   (coef_cos),
    .coef_neg   (coef_neg),
    .coef_zero  (coef_zero)
  );

  function automatic logic [1:0] axis_of(input logic [IW-1:0] idx);
    axis_of = (idx >= tes_pkg::AXES_PER_NODE) ? 2'(idx - tes_pkg::AXES_PER_NODE) : idx[1:0];
  endfunction

  // emitter sequencer state
  logic                             emit_busy_r;
  logic [IW-1:0]                    row_r, col_r;
  logic [KW-1:0]                    k_r;
  logic [tes_pkg::AXES-1:0][CW-1:0] cos_r;
  logic [tes_pkg::AXES-1:0]         cneg_r;
  logic                             zero_r;

  // pipeline stages
  logic            v1_r, v2_r, v3_r;
  logic [IW-1:0]   row1_r, col1_r, row2_r, col2_r, row3_r, col3_r;
  logic            neg1_r, neg2_r, neg3_r;
  logic            zero1_r, zero2_r, zero3_r;
  logic            last1_r, last2_r, last3_r;
  logic [CCW-1:0]  cc1_r;
  logic [KW-1:0]   k1_r;
  logic [PPW-1:0]  pp0_r, pp1_r, pp2_r, pp3_r;
  logic [SW-1:0]   sa_r, sb_r;

  // output register
  logic            out_valid_r;
  logic [IW-1:0]   out_row_r, out_col_r;
  logic [VW-1:0]   out_val_r;
  logic            out_zero_r, out_last_r;

  logic            adv, issue, issue_last, coef_take;
  logic [1:0]      ai, aj;
  logic            off_block;
  logic [PW-1:0]   p_full;
  logic [FW-1:0]   mag;
  logic            hi_nz, pos_over, neg_over;
  logic [VW-1:0]   val_nxt;

  assign adv        = !out_valid_r || out_word.ready;
  assign issue      = emit_busy_r && adv;
  assign issue_last = issue && (row_r == tes_pkg::LAST_IDX) && (col_r == tes_pkg::LAST_IDX);
  assign coef_ready = !emit_busy_r || issue_last;
  assign coef_take  = coef_valid && coef_ready;

  assign ai        = axis_of(row_r);
  assign aj        = axis_of(col_r);
  assign off_block = (row_r >= tes_pkg::AXES_PER_NODE) != (col_r >= tes_pkg::AXES_PER_NODE);

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_busy_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      if (coef_take) begin
        emit_busy_r <= 1'b1;
        row_r       <= '0;
        col_r       <= '0;
      end else if (issue_last) begin
        emit_busy_r <= 1'b0;
      end else if (issue) begin
        if (col_r == tes_pkg::LAST_IDX) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  // coefficients of the bar being emitted
  always_ff @(posedge clk) begin
    if (coef_take) begin
      k_r    <= coef_k;
      cos_r  <= coef_cos;
      cneg_r <= coef_neg;
      zero_r <= coef_zero;
    end
  end

  // stage valid bits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // final sum, scale and saturation
  always_comb begin
    p_full   = PW'(sa_r) + (PW'(sb_r) << 32);
    mag      = p_full[PW-1:2*FRAC_BITS];
    hi_nz    = |mag[FW-1:VW];
    pos_over = hi_nz || mag[VW-1];
    neg_over = hi_nz || (mag[VW-1] && (|mag[VW-2:0]));
    if (neg3_r) begin
      val_nxt = neg_over ? tes_pkg::VAL_NEG_LIMIT : (~mag[VW-1:0] + 1'b1);
    end else begin
      val_nxt = pos_over ? tes_pkg::VAL_POS_LIMIT : mag[VW-1:0];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // cosine product and sign
      row1_r  <= row_r;
      col1_r  <= col_r;
      k1_r    <= k_r;
      cc1_r   <= CCW'(cos_r[ai]) * CCW'(cos_r[aj]);
      neg1_r  <= cneg_r[ai] ^ cneg_r[aj] ^ off_block;
      zero1_r <= zero_r;
      last1_r <= issue_last;
      // partial products of stiffness times cosine product
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
      last2_r <= last1_r;
      pp0_r   <= PPW'(k1_r[31:0]) * PPW'(cc1_r[CW-1:0]);
      pp1_r   <= PPW'(k1_r[31:0]) * PPW'(cc1_r[CCW-1:CW]);
      pp2_r   <= PPW'(k1_r[KW-1:32]) * PPW'(cc1_r[CW-1:0]);
      pp3_r   <= PPW'(k1_r[KW-1:32]) * PPW'(cc1_r[CCW-1:CW]);
      // partial sums
      row3_r  <= row2_r;
      col3_r  <= col2_r;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      last3_r <= last2_r;
      sa_r    <= SW'(pp0_r) + (SW'(pp1_r) << CW);
      sb_r    <= SW'(pp2_r) + (SW'(pp3_r) << CW);
      // output word
      out_row_r  <= row3_r;
      out_col_r  <= col3_r;
      out_val_r  <= val_nxt;
      out_zero_r <= zero3_r;
      out_last_r <= last3_r;
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.row_index       = out_row_r;
  assign out_word.col_index       = out_col_r;
  assign out_word.stiffness_value = out_val_r;
  assign out_word.zero_length     = out_zero_r;
  assign out_word.last_entry      = out_last_r;

  // checks
  `TES_ASSERT_NOW(a_last_corner, out_valid_r && out_last_r, out_row_r == tes_pkg::LAST_IDX && out_col_r == tes_pkg::LAST_IDX, "last entry off the corner")
  `TES_ASSERT_NOW(a_zero_value, out_valid_r && out_zero_r, out_val_r == '0, "coincident nodes gave a nonzero entry")
  `TES_ASSERT_NEXT(a_coef_load, coef_take, emit_busy_r && row_r == '0 && col_r == '0, "emitter did not restart at the first entry")

endmodule

### rtl/tes_root.sv
// bar length unit: squared differences then a bit-pair square root
module tes_root (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tes_pkg::elem_t      in_elem,
  output logic                res_valid,
  input  logic                res_ready,
  output tes_pkg::root_res_t  res
);

  localparam int DW = tes_pkg::DIFF_W;
  localparam int SW = tes_pkg::SUM_W;
  localparam int LW = tes_pkg::LEN_W;
  localparam int RW = tes_pkg::REM_W;
  localparam logic [5:0] SQ_STEPS = 6'd3;
  localparam logic [5:0] LAST_CNT = 6'd35;

  logic                             busy_r;
  logic                             res_valid_r;
  logic [5:0]                       cnt_r;
  logic [tes_pkg::AXES-1:0][DW-1:0] mag_r;
  logic [tes_pkg::AXES-1:0]         neg_r;
  logic [31:0]                      mod_r;
  logic [31:0]                      area_r;
  logic [SW-1:0]                    sum_r;
  logic [RW-1:0]                    rem_r;
  logic [LW-1:0]                    root_r;

  logic                             accept;
  logic [tes_pkg::AXES-1:0][DW-1:0] diff;
  logic [tes_pkg::AXES-1:0][DW-1:0] mag_in;
  logic [tes_pkg::AXES-1:0]         neg_in;
  logic [DW-1:0]                    sq_sel;
  logic [SW-1:0]                    sq;
  logic [RW-1:0]                    rem_sh;
  logic [RW-1:0]                    trial;
  logic                             fits;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy_r && (!res_valid_r || res_ready);

  // coordinate differences and their magnitudes
  always_comb begin
    diff[0] = {in_elem.node_b_x[31], in_elem.node_b_x} - {in_elem.node_a_x[31], in_elem.node_a_x};
    diff[1] = {in_elem.node_b_y[31], in_elem.node_b_y} - {in_elem.node_a_y[31], in_elem.node_a_y};
    diff[2] = {in_elem.node_b_z[31], in_elem.node_b_z} - {in_elem.node_a_z[31], in_elem.node_a_z};
    for (int i = 0; i < tes_pkg::AXES; i++) begin
      neg_in[i] = diff[i][DW-1];
      mag_in[i] = neg_in[i] ? (~diff[i] + 1'b1) : diff[i];
    end
  end

  // one square per cycle
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    sq_sel = mag_r[0];
      2'd1:    sq_sel = mag_r[1];
      2'd2:    sq_sel = mag_r[2];
      default: sq_sel = '0;
    endcase
    sq = SW'(sq_sel) * SW'(sq_sel);
  end

  // one root digit per cycle
  always_comb begin
    rem_sh = {rem_r[RW-3:0], sum_r[SW-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      if (accept) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_CNT) begin
          busy_r      <= 1'b0;
          res_valid_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r  <= mag_in;
      neg_r  <= neg_in;
      mod_r  <= in_elem.elastic_modulus;
      area_r <= in_elem.cross_area;
      sum_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < SQ_STEPS) begin
        sum_r <= sum_r + sq;
      end else begin
        sum_r  <= {sum_r[SW-3:0], 2'b00};
        rem_r  <= fits ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[LW-2:0], fits};
      end
    end
  end

  assign res_valid   = res_valid_r;
  assign res.len     = root_r;
  assign res.mag     = mag_r;
  assign res.neg     = neg_r;
  assign res.modulus = mod_r;
  assign res.area    = area_r;

endmodule

### rtl/tes_div.sv
// divider unit: axial stiffness two bits a cycle, direction cosines in three lanes
module tes_div #(
  parameter int FRAC_BITS = tes_pkg::FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   src_valid,
  output logic                                   src_ready,
  input  tes_pkg::root_res_t                     src,
  output logic                                   coef_valid,
  input  logic                                   coef_ready,
  output logic [tes_pkg::PROD_W-1:0]             coef_k,
  output logic [tes_pkg::AXES-1:0][FRAC_BITS:0]  coef_cos,
  output logic [tes_pkg::AXES-1:0]               coef_neg,
  output logic                                   coef_zero
);

  localparam int CW = FRAC_BITS + 1;
  localparam int LW = tes_pkg::LEN_W;
  localparam int PW = tes_pkg::PROD_W;
  localparam logic [4:0] LAST_CNT = 5'd31;

  logic                             busy_r;
  logic                             done_r;
  logic [4:0]                       cnt_r;
  logic [LW-1:0]                    len_r;
  logic [PW-1:0]                    quot_r;
  logic [LW-1:0]                    krem_r;
  logic [tes_pkg::AXES-1:0][LW-1:0] crem_r;
  logic [tes_pkg::AXES-1:0][CW-1:0] cq_r;
  logic [tes_pkg::AXES-1:0]         neg_r;
  logic                             zero_r;

  logic                             accept;
  logic                             len_zero;
  logic [LW:0]                      r1, r2, s1, s2;
  logic                             g1, g2;
  logic [tes_pkg::AXES-1:0]         ge0;
  logic [tes_pkg::AXES-1:0][LW:0]   cr;
  logic [tes_pkg::AXES-1:0]         cg;

  assign accept    = src_valid && src_ready;
  assign src_ready = !busy_r && (!done_r || coef_ready);
  assign len_zero  = (src.len == '0);

  // two restoring steps of the stiffness quotient
  always_comb begin
    r1 = {krem_r, quot_r[PW-1]};
    g1 = r1 >= {1'b0, len_r};
    s1 = g1 ? (r1 - {1'b0, len_r}) : r1;
    r2 = {s1[LW-1:0], quot_r[PW-2]};
    g2 = r2 >= {1'b0, len_r};
    s2 = g2 ? (r2 - {1'b0, len_r}) : r2;
  end

  // cosine lanes: integer bit at load, one fraction bit per step
  always_comb begin
    for (int i = 0; i < tes_pkg::AXES; i++) begin
      ge0[i] = !len_zero && (src.mag[i] >= src.len);
      cr[i]  = {crem_r[i], 1'b0};
      cg[i]  = cr[i] >= {1'b0, len_r};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (done_r && coef_ready) begin
        done_r <= 1'b0;
      end
      if (accept) begin
        cnt_r <= '0;
        if (len_zero) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      len_r  <= src.len;
      neg_r  <= src.neg;
      zero_r <= len_zero;
      krem_r <= '0;
      quot_r <= len_zero ? '0 : (PW'(src.modulus) * PW'(src.area));
      for (int i = 0; i < tes_pkg::AXES; i++) begin
        cq_r[i]   <= CW'(ge0[i]);
        crem_r[i] <= ge0[i] ? (src.mag[i] - src.len) : src.mag[i];
      end
    end else if (busy_r) begin
      krem_r <= s2[LW-1:0];
      quot_r <= {quot_r[PW-3:0], g1, g2};
      if (cnt_r < 5'(FRAC_BITS)) begin
        for (int i = 0; i < tes_pkg::AXES; i++) begin
          cq_r[i]   <= {cq_r[i][CW-2:0], cg[i]};
          crem_r[i] <= cg[i] ? LW'(cr[i] - {1'b0, len_r}) : cr[i][LW-1:0];
        end
      end
    end
  end

  assign coef_valid = done_r;
  assign coef_k     = quot_r;
  assign coef_cos   = cq_r;
  assign coef_neg   = neg_r;
  assign coef_zero  = zero_r;

endmodule

### tb/tb_truss_element_stiffness_3d.sv
// testbench for the space truss element stiffness matrix generator
`timescale 1ns / 100ps

module tb_truss_element_stiffness_3d;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 150;
  localparam int ENTRIES      = 36;
  localparam int IDX_W        = tes_pkg::IDX_W;
  localparam int VAL_W        = tes_pkg::VAL_W;
  localparam int FRAC_BITS    = tes_pkg::FRAC_BITS;

  // one matrix entry as it should leave the block
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    zero_len;
    logic                    last;
  } entry_t;

  // expected matrix entries and their check against the block
  class stiffness_board;
    entry_t matrix_q[$];
    int     mismatches;
    int     bars_seen;
    int     entries_seen;
    int     zero_bars;
    int     clipped_entries;

    // work out the 36 entries of one bar
    function void note_bar(tes_pkg::elem_t e);
      logic signed [31:0] pa[3];
      logic signed [31:0] pb[3];
      logic [32:0]  dmag[3];
      bit           dneg[3];
      logic [71:0]  sq_sum;
      logic [35:0]  len;
      logic [35:0]  trial;
      logic [63:0]  cmag[3];
      logic [63:0]  axial_k;
      logic [127:0] prod;
      logic [127:0] mag;
      longint       diff;
      bit           zero, neg;
      entry_t       x;
      pa = '{e.node_a_x, e.node_a_y, e.node_a_z};
      pb = '{e.node_b_x, e.node_b_y, e.node_b_z};
      sq_sum = '0;
      for (int i = 0; i < 3; i++) begin
        diff = longint'(pb[i]) - longint'(pa[i]);
        dneg[i] = diff < 0;
        dmag[i] = diff < 0 ? 33'(-diff) : 33'(diff);
        sq_sum += 72'(dmag[i]) * 72'(dmag[i]);
      end
      // bitwise integer square root
      len = '0;
      for (int b = 35; b >= 0; b--) begin
        trial = len | (36'd1 << b);
        if (72'(trial) * 72'(trial) <= sq_sum) len = trial;
      end
      zero = (len == 0);
      axial_k = '0;
      for (int i = 0; i < 3; i++) begin
        cmag[i] = zero ? 64'd0 : (64'(dmag[i]) << FRAC_BITS) / 64'(len);
        if (cmag[i] == 0) dneg[i] = 1'b0;
      end
      if (!zero) axial_k = (64'(e.elastic_modulus) * 64'(e.cross_area)) / 64'(len);
      for (int i = 0; i < 6; i++) begin
        for (int j = 0; j < 6; j++) begin
          x = '0;
          x.row = IDX_W'(i);
          x.col = IDX_W'(j);
          x.zero_len = zero;
          x.last = (i == 5 && j == 5);
          if (!zero) begin
            prod = 128'(axial_k) * 128'(cmag[i % 3] * cmag[j % 3]);
            mag = prod >> (2 * FRAC_BITS);
            neg = dneg[i % 3] ^ dneg[j % 3] ^ ((i < 3) != (j < 3));
            if (neg) begin
              if (mag > 128'(tes_pkg::VAL_NEG_LIMIT)) begin
                mag = 128'(tes_pkg::VAL_NEG_LIMIT);
                clipped_entries++;
              end
              x.value = -mag[VAL_W-1:0];
            end else begin
              if (mag > 128'(tes_pkg::VAL_POS_LIMIT)) begin
                mag = 128'(tes_pkg::VAL_POS_LIMIT);
                clipped_entries++;
              end
              x.value = mag[VAL_W-1:0];
            end
          end
          matrix_q.push_back(x);
        end
      end
      bars_seen++;
      if (zero) zero_bars++;
    endfunction

    // compare one received entry with the oldest expected one
    function void check_entry(entry_t got);
      entry_t want;
      entries_seen++;
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected entry row %0d col %0d value %0d", got.row, got.col,
                   got.value);
        return;
      end
      want = matrix_q.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.value !== want.value ||
          got.zero_len !== want.zero_len || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("entry mismatch: exp r%0d c%0d v%0d z%0b l%0b, got r%0d c%0d v%0d z%0b l%0b",
                   want.row, want.col, want.value, want.zero_len, want.last,
                   got.row, got.col, got.value, got.zero_len, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tes_in_if  in_if();
  tes_out_if out_if();

  stiffness_board board;
  int idle_pct;
  int stall_pct;
  int hold_cycles;
  int cycle_cnt;

  truss_element_stiffness_3d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.check_entry({out_if.row_index, out_if.col_index, out_if.stiffness_value,
                         out_if.zero_length, out_if.last_entry});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one bar and wait for it to be taken
  task automatic send_bar(tes_pkg::elem_t e);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.node_a_x        <= e.node_a_x;
    in_if.node_a_y        <= e.node_a_y;
    in_if.node_a_z        <= e.node_a_z;
    in_if.node_b_x        <= e.node_b_x;
    in_if.node_b_y        <= e.node_b_y;
    in_if.node_b_z        <= e.node_b_z;
    in_if.elastic_modulus <= e.elastic_modulus;
    in_if.cross_area      <= e.cross_area;
    do @(posedge clk); while (!in_if.ready);
    board.note_bar(e);
  endtask

  // build a bar from node a plus an offset
  function automatic tes_pkg::elem_t make_bar(logic [31:0] ax, logic [31:0] ay,
                                              logic [31:0] az, logic [31:0] dx,
                                              logic [31:0] dy, logic [31:0] dz,
                                              logic [31:0] em, logic [31:0] ar);
    tes_pkg::elem_t e;
    e.node_a_x = ax;
    e.node_a_y = ay;
    e.node_a_z = az;
    e.node_b_x = ax + dx;
    e.node_b_y = ay + dy;
    e.node_b_z = az + dz;
    e.elastic_modulus = em;
    e.cross_area = ar;
    return e;
  endfunction

  // signed offset within +-2^span
  function automatic logic [31:0] rand_offset(int span);
    logic [31:0] v;
    v = $urandom_range((1 << span) - 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  // random bar: full range, ordinary members, or very short ones
  function automatic tes_pkg::elem_t rand_bar();
    int kind;
    int span;
    kind = $urandom_range(9);
    span = $urandom_range(24, 2);
    if (kind < 3)
      return make_bar($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
    if (kind < 8)
      return make_bar($urandom, $urandom, $urandom, rand_offset(span), rand_offset(span),
                      rand_offset(span), $urandom_range(32'h00FF_FFFF),
                      $urandom_range(32'h0003_FFFF));
    return make_bar($urandom, $urandom, $urandom, rand_offset(1), rand_offset(1),
                    rand_offset(1), $urandom, $urandom);
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_bar(rand_bar());
  endtask

  localparam logic [31:0] ONE   = 32'h0001_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] U_MAX = 32'hFFFF_FFFF;

  initial begin
    board = new();
    cycle_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    {in_if.node_a_x, in_if.node_a_y, in_if.node_a_z} = '0;
    {in_if.node_b_x, in_if.node_b_y, in_if.node_b_z} = '0;
    in_if.elastic_modulus = '0;
    in_if.cross_area = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed bars: axes, signs, coincident nodes, extremes, clipping
    send_bar(make_bar(0, 0, 0, ONE, 0, 0, ONE, ONE));
    send_bar(make_bar(0, 0, 0, 0, -ONE, 0, ONE, ONE));
    send_bar(make_bar(ONE, ONE, ONE, 0, 0, 3 * ONE, 200 * ONE, ONE / 2));
    send_bar(make_bar(0, 0, 0, ONE, -ONE, ONE, 10 * ONE, ONE));
    send_bar(make_bar(0, 0, 0, -3 * ONE, 4 * ONE, 0, ONE, ONE));
    send_bar(make_bar(ONE, -ONE, 5 * ONE, 0, 0, 0, ONE, ONE));
    send_bar(make_bar(S_MAX, S_MIN, 0, 0, 0, 0, U_MAX, U_MAX));
    send_bar(make_bar(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, U_MAX, U_MAX));
    send_bar(make_bar(S_MAX, S_MAX, S_MAX, S_MIN + 1, S_MIN + 1, S_MIN + 1, 0, U_MAX));
    send_bar(make_bar(S_MIN, 0, S_MAX, S_MAX, 0, S_MIN + 1, U_MAX, 0));
    send_bar(make_bar(0, 0, 0, 1, 0, 0, U_MAX, U_MAX));
    send_bar(make_bar(0, 0, 0, 1, -1, 1, U_MAX, U_MAX));
    send_bar(make_bar(S_MAX, 0, 0, -1, 0, 0, U_MAX, 1));
    send_bar(make_bar(0, 0, 0, ONE, ONE, 0, 0, 0));
    send_bar(make_bar(0, 0, 0, 0, 0, 0, 0, 0));
    send_bar(make_bar(0, 0, 0, 1, 2, 3, 1, 1));
    send_bar(make_bar(0, 0, 0, -7, 1000 * ONE, 3, 50 * ONE, 5 * ONE));
    send_bar(make_bar(U_MAX, U_MAX, U_MAX, 2, -2, 1, 32'h5555_5555, 32'hAAAA_AAAA));

    // receiver holds off while bars keep coming
    hold_cycles = 400;
    random_phase(10, 0, 0);

    random_phase(60, 0, 0);
    random_phase(60, 57, 0);
    random_phase(60, 0, 57);
    random_phase(55, 25, 25);
    in_if.valid <= 1'b0;

    while (board.matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("bars %0d (coincident %0d), entries checked %0d, clipped %0d, mismatches %0d",
             board.bars_seen, board.zero_bars, board.entries_seen, board.clipped_entries,
             board.mismatches);
    $display("covered axis and skew bars, extreme coordinates, idle and stall phases");
    if (board.mismatches == 0 && board.matrix_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/tes_pkg.sv
rtl/tes_if.sv
rtl/tes_root.sv
rtl/tes_div.sv
rtl/truss_element_stiffness_3d.sv
tb/tb_truss_element_stiffness_3d.sv
